// File: rtl/time_of_day_clock_12_24_unit_defines.svh
// ----------------------------------------------------------------------------
// Time-of-day clock assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_CLOCK_12_24_UNIT_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_12_24_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define TOD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define TOD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TOD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tod_pkg.sv
// ----------------------------------------------------------------------------
// Time-of-day clock package
// Field widths, command codes, result type and modulo helpers.
// ----------------------------------------------------------------------------
package tod_pkg;

	// Field widths.
	localparam int CMD_W  = 3;
	localparam int SET_W  = 8;
	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int SEC_W  = 6;

	// Counter bounds.
	localparam logic [MIN_W-1:0]  MIN_MAX     = 6'd59;
	localparam logic [SEC_W-1:0]  SEC_MAX     = 6'd59;
	localparam logic [HOUR_W-1:0] HOUR_MAX_24 = 5'd23;
	localparam logic [HOUR_W-1:0] HOUR_MIN_24 = 5'd0;
	localparam logic [HOUR_W-1:0] HOUR_MAX_12 = 5'd12;
	localparam logic [HOUR_W-1:0] HOUR_MIN_12 = 5'd1;
	localparam logic [HOUR_W-1:0] HOUR_PRE_12 = 5'd11;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_SET    = 3'd1,
		CMD_INC_HR = 3'd2,
		CMD_DEC_HR = 3'd3,
		CMD_INC_MN = 3'd4,
		CMD_DEC_MN = 3'd5,
		CMD_TOG_PM = 3'd6
	} tod_cmd_code_t;

	// One command as held in the input register.
	typedef struct packed {
		tod_cmd_code_t    cmd;
		logic [SET_W-1:0] set_hours;
		logic [SET_W-1:0] set_minutes;
		logic [SET_W-1:0] set_seconds;
	} tod_cmd_t;

	// One result as held in the output register.
	typedef struct packed {
		logic [HOUR_W-1:0] hours;
		logic [MIN_W-1:0]  minutes;
		logic [SEC_W-1:0]  seconds;
		logic              is_pm;
		logic              minute_rolled;
	} tod_result_t;

	// Byte modulo 60: 64 is 4 mod 60, so fold the top two bits, then one subtract.
	function automatic logic [MIN_W-1:0] mod60(input logic [SET_W-1:0] x);
		logic [6:0] y;
		y = {1'b0, x[5:0]} + {3'b000, x[7:6], 2'b00};
		if (y >= 7'd60) begin
			y = y - 7'd60;
		end
		return y[5:0];
	endfunction

	// Byte modulo 24: 32 is 8 mod 24, folded twice, then one subtract.
	function automatic logic [HOUR_W-1:0] mod24(input logic [SET_W-1:0] x);
		logic [6:0] y;
		logic [5:0] z;
		y = {2'b00, x[4:0]} + {1'b0, x[7:5], 3'b000};
		z = {1'b0, y[4:0]} + {1'b0, y[6:5], 3'b000};
		if (z >= 6'd24) begin
			z = z - 6'd24;
		end
		return z[4:0];
	endfunction

endpackage

// File: rtl/tod_ifs.sv
// ----------------------------------------------------------------------------
// Time-of-day clock channel interfaces
// Valid/ready channels for commands, results and the mode register write.
// ----------------------------------------------------------------------------

// Command channel.
interface tod_cmd_if import tod_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [SET_W-1:0] set_hours;
	logic [SET_W-1:0] set_minutes;
	logic [SET_W-1:0] set_seconds;

	modport source (output valid, cmd, set_hours, set_minutes, set_seconds,
		input ready);
	modport sink (input valid, cmd, set_hours, set_minutes, set_seconds,
		output ready);
endinterface

// Result channel.
interface tod_time_if import tod_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [HOUR_W-1:0] hours;
	logic [MIN_W-1:0]  minutes;
	logic [SEC_W-1:0]  seconds;
	logic              is_pm;
	logic              minute_rolled;

	modport source (output valid, hours, minutes, seconds, is_pm, minute_rolled,
		input ready);
	modport sink (input valid, hours, minutes, seconds, is_pm, minute_rolled,
		output ready);
endinterface

// Mode register write channel.
interface tod_cfg_if;
	logic valid;
	logic ready;
	logic mode_24h;

	modport source (output valid, mode_24h, input ready);
	modport sink (input valid, mode_24h, output ready);
endinterface

// File: rtl/tod_in_stage.sv
// ----------------------------------------------------------------------------
// Time-of-day clock input stage
// Registers one command; takes a new one when empty or when the held one moves on.
// ----------------------------------------------------------------------------
module tod_in_stage import tod_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tod_cmd_if.sink   cmd_ch,
	input  logic      adv,
	output logic      valid_s1,
	output tod_cmd_t  cmd_s1
);

	// The stage frees up in the same cycle its command is consumed.
	assign cmd_ch.ready = !valid_s1 || adv;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	// Command payload, loaded on each transfer.
	always_ff @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			cmd_s1.cmd         <= tod_cmd_code_t'(cmd_ch.cmd);
			cmd_s1.set_hours   <= cmd_ch.set_hours;
			cmd_s1.set_minutes <= cmd_ch.set_minutes;
			cmd_s1.set_seconds <= cmd_ch.set_seconds;
		end
	end

endmodule

// File: rtl/tod_core.sv
// ----------------------------------------------------------------------------
// Time-of-day clock core
// Holds the time counters and mode, and applies one command per cycle while results are taken.
// ----------------------------------------------------------------------------
module tod_core import tod_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tod_cfg_if.sink     cfg_ch,
	input  logic        adv,
	input  tod_cmd_t    cmd_s1,
	output tod_result_t next_res
);

	logic              mode_q;
	logic [HOUR_W-1:0] hour_q;
	logic [MIN_W-1:0]  min_q;
	logic [SEC_W-1:0]  sec_q;
	logic              pm_q;

	logic [HOUR_W-1:0] hr_max;
	logic [HOUR_W-1:0] hr_min;
	logic [HOUR_W-1:0] set_h24;
	logic [HOUR_W-1:0] set_h12;
	logic [HOUR_W-1:0] hour_d;
	logic [MIN_W-1:0]  min_d;
	logic [SEC_W-1:0]  sec_d;
	logic              pm_d;
	logic              rolled_d;

	// The mode register accepts a write in any cycle.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_ch.valid) begin
			mode_q <= cfg_ch.mode_24h;
		end
	end

	// Hour bounds of the current mode.
	assign hr_max = mode_q ? HOUR_MAX_24 : HOUR_MAX_12;
	assign hr_min = mode_q ? HOUR_MIN_24 : HOUR_MIN_12;

	// Folded set hour: mod 24, and for 12-hour counting mod 12 with zero shown as 12.
	always_comb begin
		set_h24 = mod24(cmd_s1.set_hours);
		if (set_h24 >= HOUR_MAX_12) begin
			set_h12 = set_h24 - HOUR_MAX_12;
		end else begin
			set_h12 = set_h24;
		end
		if (set_h12 == '0) begin
			set_h12 = HOUR_MAX_12;
		end
	end

	// Next state for the command in the input register.
	always_comb begin
		hour_d   = hour_q;
		min_d    = min_q;
		sec_d    = sec_q;
		pm_d     = pm_q;
		rolled_d = 1'b0;
		unique case (cmd_s1.cmd)
			CMD_TICK: begin
				if (sec_q >= SEC_MAX) begin
					sec_d    = '0;
					rolled_d = 1'b1;
					if (min_q >= MIN_MAX) begin
						min_d = '0;
						if (mode_q) begin
							hour_d = (hour_q >= HOUR_MAX_24) ? '0 : hour_q + 5'd1;
						end else if (hour_q >= HOUR_MAX_12) begin
							hour_d = HOUR_MIN_12;
						end else if (hour_q == HOUR_PRE_12) begin
							hour_d = HOUR_MAX_12;
							pm_d   = !pm_q;
						end else begin
							hour_d = hour_q + 5'd1;
						end
					end else begin
						min_d = min_q + 6'd1;
					end
				end else begin
					sec_d = sec_q + 6'd1;
				end
			end
			CMD_SET: begin
				hour_d = mode_q ? set_h24 : set_h12;
				min_d  = mod60(cmd_s1.set_minutes);
				sec_d  = mod60(cmd_s1.set_seconds);
			end
			CMD_INC_HR: begin
				if (hour_q < hr_max) begin
					hour_d = hour_q + 5'd1;
				end
			end
			CMD_DEC_HR: begin
				if (hour_q > hr_min) begin
					hour_d = hour_q - 5'd1;
				end
			end
			CMD_INC_MN: begin
				if (min_q < MIN_MAX) begin
					min_d = min_q + 6'd1;
				end
			end
			CMD_DEC_MN: begin
				if (min_q != '0) begin
					min_d = min_q - 6'd1;
				end
			end
			CMD_TOG_PM: begin
				pm_d = !pm_q;
			end
			default: begin
				// The unused code leaves the time as it is.
			end
		endcase
	end

	assign next_res.hours         = hour_d;
	assign next_res.minutes       = min_d;
	assign next_res.seconds       = sec_d;
	assign next_res.is_pm         = pm_d;
	assign next_res.minute_rolled = rolled_d;

	// Time counters, updated when a command moves on to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q <= '0;
			min_q  <= '0;
			sec_q  <= '0;
			pm_q   <= 1'b0;
		end else if (adv) begin
			hour_q <= hour_d;
			min_q  <= min_d;
			sec_q  <= sec_d;
			pm_q   <= pm_d;
		end
	end

endmodule

// File: rtl/tod_out_stage.sv
// ----------------------------------------------------------------------------
// Time-of-day clock output stage
// Result register that holds a result until its transfer completes.
// ----------------------------------------------------------------------------
module tod_out_stage import tod_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  tod_result_t res,
	output logic        can_load,
	tod_time_if.source  result_ch
);

	logic        valid_s2;
	tod_result_t res_s2;

	// A new result may enter when the register is empty or being drained.
	assign can_load = !valid_s2 || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (result_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

	// Drive the result channel.
	assign result_ch.valid         = valid_s2;
	assign result_ch.hours         = res_s2.hours;
	assign result_ch.minutes       = res_s2.minutes;
	assign result_ch.seconds       = res_s2.seconds;
	assign result_ch.is_pm         = res_s2.is_pm;
	assign result_ch.minute_rolled = res_s2.minute_rolled;

endmodule

// File: rtl/time_of_day_clock_12_24_unit.sv
// Path: a command is held in the input register, and its result is then registered in
// the result register and presented on the result channel.
// Throughput: one command per cycle while results are taken; the counters update
// through the logic between the input and result registers.
// Reset: time 00:00:00 AM, 12-hour mode, both stages empty.
// ----------------------------------------------------------------------------
// Time-of-day clock, 12/24 hour
// Command-driven hours/minutes/seconds counter with AM/PM and a minute carry pulse.
// ----------------------------------------------------------------------------
`include "time_of_day_clock_12_24_unit_defines.svh"

module time_of_day_clock_12_24_unit import tod_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tod_cfg_if.sink    cfg,
	tod_cmd_if.sink    cmd,
	tod_time_if.source result
);

	logic        valid_s1;
	tod_cmd_t    cmd_s1;
	logic        can_load;
	logic        adv;
	tod_result_t next_res;

	// A command moves on when the result register can take its result.
	assign adv = valid_s1 && can_load;

	tod_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_ch   (cmd),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.cmd_s1   (cmd_s1)
	);

	tod_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_ch   (cfg),
		.adv      (adv),
		.cmd_s1   (cmd_s1),
		.next_res (next_res)
	);

	tod_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res       (next_res),
		.can_load  (can_load),
		.result_ch (result)
	);

	// A full input stage that cannot move on must not take another command.
	`TOD_ASSERT_IMPLY(a_no_overrun, valid_s1 && !adv, !cmd.ready, "command taken over a held one")
	// Shown time stays in range.
	`TOD_ASSERT_IMPLY(a_time_range, result.valid,
		(result.hours <= HOUR_MAX_24) && (result.minutes <= MIN_MAX) &&
		(result.seconds <= SEC_MAX), "time out of range")
	// A minute carry leaves the seconds at zero.
	`TOD_ASSERT_IMPLY(a_roll_secs, result.valid && result.minute_rolled,
		result.seconds == '0, "carry with nonzero seconds")

endmodule
